### rtl/tbrm_pkg.sv
package tbrm_pkg;

  localparam int unsigned NUM_TRIGGER_BITS = 8;
  localparam int unsigned COUNTER_WIDTH    = 24;
  localparam int unsigned OUT_LINES        = 8;
  localparam int unsigned COUNT_OUT_W      = 24;

  localparam int unsigned TIME_NS_W = 64;
  localparam int unsigned BITS_IN_W = 8;
  localparam int unsigned MS_W      = 45;
  localparam int unsigned GAP_W     = 16;
  localparam int unsigned WIN_W     = 17;
  localparam int unsigned TOTAL_W   = 48;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT_MS = 1'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET_VALUE  = 16'd1000;

  // 1e6 = 2^6 * 15625: shift off six bits, then multiply by ceil(2^72 / 15625)
  // and keep bits from 72 up. Exact for 58-bit dividends: the rounding error
  // of the reciprocal is below 2^14.
  localparam int unsigned DIV_SHIFT  = 6;
  localparam int unsigned DIV_X_W    = TIME_NS_W - DIV_SHIFT;
  localparam int unsigned DIV_M_W    = 59;
  localparam int unsigned DIV_LO_W   = 29;
  localparam int unsigned DIV_FRAC   = 72;
  localparam int unsigned DIV_STAGES = 3;
  localparam logic [72:0] DIV_RECIP_FULL = (73'd1 << 72) / 73'd15625 + 73'd1;
  localparam logic [DIV_M_W-1:0] DIV_RECIP = DIV_RECIP_FULL[DIV_M_W-1:0];

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 240;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = 2;

  typedef struct packed {
    logic [MS_W-1:0]             now_ms;
    logic [NUM_TRIGGER_BITS-1:0] bits;
  } evt_t;

  typedef struct packed {
    logic [CFG_W-1:0] window_ms;
    logic [CFG_W-1:0] gap_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]                     total_time_ms;
    logic [OUT_LINES-1:0][COUNT_OUT_W-1:0]  count;
    logic                                   window_done;
  } res_t;

endpackage

### rtl/trigger_bit_rate_meter.sv
// Trigger bit rate meter.
// Input stream s_axis: one request per event, tdata = event time in ns and
// the trigger bits. Output stream m_axis: one request per event with the
// total accepted time and, when the event closes a window, the per-line
// counts (window_done in tuser).
// Config: cfg_we_i writes window_ms (index 0) or gap_limit_ms (index 1);
// write only while no event is in flight.
// Throughput: one event per cycle unless m_axis stalls. The ns to ms conversion is a
// 3-stage reciprocal multiply pipeline (partial products, middle sum, final sum),
// followed by a 4-entry queue and a state update into the output register.
// Reset: both registers go to 1000, times and counters to zero, all
// pipeline, queue and output valids clear.
// Stall: a held m_axis request keeps the output register; the queue fills,
// the divider pipeline freezes and s_axis_tready drops. No request is lost.
module trigger_bit_rate_meter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [63:0] event_time_ns, [71:64] trigger_bits
  input  logic [tbrm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [23:0] count_0 ... [191:168] count_7, [239:192] total_time_ms
  output logic [tbrm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] window_done
  output logic [0:0]                          m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [tbrm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tbrm_pkg::CFG_W-1:0]          cfg_wdata_i
);

  tbrm_pkg::cfg_t cfg_q;
  tbrm_pkg::evt_t div_evt, q_evt;
  tbrm_pkg::res_t res;
  logic           div_valid, div_ready;
  logic           q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ms    <= tbrm_pkg::CFG_RESET_VALUE;
      cfg_q.gap_limit_ms <= tbrm_pkg::CFG_RESET_VALUE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbrm_pkg::CFG_WINDOW_MS:    cfg_q.window_ms    <= cfg_wdata_i;
        tbrm_pkg::CFG_GAP_LIMIT_MS: cfg_q.gap_limit_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tbrm_divider u_divider (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_time_ns_i (s_axis_tdata[tbrm_pkg::TIME_NS_W-1:0]),
    .in_bits_i    (s_axis_tdata[tbrm_pkg::TIME_NS_W +: tbrm_pkg::NUM_TRIGGER_BITS]),
    .out_valid_o  (div_valid),
    .out_ready_i  (div_ready),
    .out_evt_o    (div_evt)
  );

  tbrm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (div_valid),
    .push_ready_o (div_ready),
    .push_data_i  (div_evt),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_evt)
  );

  tbrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_evt_i    (q_evt),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {res.total_time_ms, res.count};
  assign m_axis_tuser = res.window_done;

endmodule

### rtl/tbrm_divider.sv
module tbrm_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [tbrm_pkg::TIME_NS_W-1:0]       in_time_ns_i,
  input  logic [tbrm_pkg::NUM_TRIGGER_BITS-1:0] in_bits_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tbrm_pkg::evt_t                       out_evt_o
);

  localparam int unsigned LO_W  = tbrm_pkg::DIV_LO_W;
  localparam int unsigned XH_W  = tbrm_pkg::DIV_X_W - LO_W;
  localparam int unsigned M_W   = tbrm_pkg::DIV_M_W;
  localparam int unsigned MH_W  = M_W - LO_W;
  localparam int unsigned P_W   = tbrm_pkg::DIV_X_W + M_W;
  localparam int unsigned MID_W = M_W + 1;
  localparam int unsigned LL_W  = LO_W + LO_W;
  localparam int unsigned LH_W  = LO_W + MH_W;
  localparam int unsigned HL_W  = XH_W + LO_W;
  localparam int unsigned HH_W  = XH_W + MH_W;
  localparam int unsigned NB    = tbrm_pkg::NUM_TRIGGER_BITS;
  localparam int unsigned MS_W  = tbrm_pkg::MS_W;
  localparam int unsigned NSTG  = tbrm_pkg::DIV_STAGES;

  localparam logic [LO_W-1:0] RECIP_LO = tbrm_pkg::DIV_RECIP[LO_W-1:0];
  localparam logic [MH_W-1:0] RECIP_HI = tbrm_pkg::DIV_RECIP[M_W-1:LO_W];

  logic [LO_W-1:0]  xl;
  logic [XH_W-1:0]  xh;
  logic [LL_W-1:0]  pp_ll_q;
  logic [LH_W-1:0]  pp_lh_q;
  logic [HL_W-1:0]  pp_hl_q;
  logic [HH_W-1:0]  pp_hh_q;
  logic [P_W-1:0]   lo_q;
  logic [MID_W-1:0] mid_q;
  logic [P_W-1:0]   prod;
  logic [MS_W-1:0]  ms_q;
  logic [NB-1:0]    bits0_q, bits1_q, bits2_q;
  logic [NSTG-1:0]  vld_q;
  logic             adv;

  // ns >> 6 split into two 29-bit halves
  assign xl = in_time_ns_i[tbrm_pkg::DIV_SHIFT +: LO_W];
  assign xh = in_time_ns_i[tbrm_pkg::TIME_NS_W-1 -: XH_W];

  // high and low partial products sit side by side without overlap
  assign prod = lo_q + P_W'({mid_q, {LO_W{1'b0}}});

  assign adv        = !(vld_q[NSTG-1] && !out_ready_i);
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_ll_q <= LL_W'(xl) * LL_W'(RECIP_LO);
      pp_lh_q <= LH_W'(xl) * LH_W'(RECIP_HI);
      pp_hl_q <= HL_W'(xh) * HL_W'(RECIP_LO);
      pp_hh_q <= HH_W'(xh) * HH_W'(RECIP_HI);
      bits0_q <= in_bits_i;
      lo_q    <= {pp_hh_q, pp_ll_q};
      mid_q   <= MID_W'(pp_lh_q) + MID_W'(pp_hl_q);
      bits1_q <= bits0_q;
      ms_q    <= prod[tbrm_pkg::DIV_FRAC +: MS_W];
      bits2_q <= bits1_q;
    end
  end

  assign out_valid_o      = vld_q[NSTG-1];
  assign out_evt_o.now_ms = ms_q;
  assign out_evt_o.bits   = bits2_q;

endmodule

### rtl/tbrm_fifo.sv
module tbrm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tbrm_pkg::evt_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tbrm_pkg::evt_t pop_data_o
);

  localparam int unsigned PW = tbrm_pkg::FIFO_PTR_W;

  tbrm_pkg::evt_t  mem_q [tbrm_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != (PW+1)'(tbrm_pkg::FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/tbrm_back.sv
module tbrm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tbrm_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tbrm_pkg::evt_t in_evt_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tbrm_pkg::res_t out_res_o
);

  localparam int unsigned MS_W  = tbrm_pkg::MS_W;
  localparam int unsigned WIN_W = tbrm_pkg::WIN_W;
  localparam int unsigned TOT_W = tbrm_pkg::TOTAL_W;
  localparam int unsigned CW    = tbrm_pkg::COUNTER_WIDTH;
  localparam int unsigned NB    = tbrm_pkg::NUM_TRIGGER_BITS;

  logic [MS_W-1:0]  prev_q, prev_d;
  logic [WIN_W-1:0] win_q, win_d;
  logic [TOT_W-1:0] acc_q, acc_d;
  logic [CW-1:0]    cnt_q [NB];
  logic [CW-1:0]    cnt_d [NB];
  logic [CW-1:0]    cnt_new [NB];

  logic                      out_vld_q;
  tbrm_pkg::res_t            res_q, res_d;
  logic                      fire;
  logic [MS_W-1:0]           diff;
  logic [tbrm_pkg::GAP_W-1:0] gap;
  logic [TOT_W:0]            acc_sum;
  logic [WIN_W:0]            win_sum;
  logic [WIN_W-1:0]          win_new;
  logic                      done;

  assign in_ready_o = !out_vld_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    diff = (in_evt_i.now_ms >= prev_q) ? in_evt_i.now_ms - prev_q
                                       : prev_q - in_evt_i.now_ms;
    gap  = (diff > MS_W'(cfg_i.gap_limit_ms)) ? '0 : diff[tbrm_pkg::GAP_W-1:0];

    acc_sum = {1'b0, acc_q} + (TOT_W+1)'(gap);
    win_sum = {1'b0, win_q} + (WIN_W+1)'(gap);
    win_new = win_sum[WIN_W] ? '1 : win_sum[WIN_W-1:0];
    done    = win_new > WIN_W'(cfg_i.window_ms);

    for (int k = 0; k < NB; k++) begin
      cnt_new[k] = (in_evt_i.bits[k] && cnt_q[k] != '1) ? cnt_q[k] + CW'(1) : cnt_q[k];
      cnt_d[k]   = done ? '0 : cnt_new[k];
    end

    prev_d = in_evt_i.now_ms;
    acc_d  = acc_sum[TOT_W] ? '1 : acc_sum[TOT_W-1:0];
    win_d  = done ? '0 : win_new;

    res_d.window_done   = done;
    res_d.total_time_ms = acc_d;
    for (int k = 0; k < tbrm_pkg::OUT_LINES; k++) begin
      res_d.count[k] = '0;
      if (k < NB && done) begin
        res_d.count[k] = tbrm_pkg::COUNT_OUT_W'(cnt_new[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      win_q     <= '0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < NB; k++) cnt_q[k] <= '0;
    end else begin
      if (fire) begin
        prev_q <= prev_d;
        win_q  <= win_d;
        acc_q  <= acc_d;
        for (int k = 0; k < NB; k++) cnt_q[k] <= cnt_d[k];
      end
      if (in_ready_o) begin
        out_vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = res_q;

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] NS_PER_MS   = 64'd1000000;
  // highest ms value whose whole ns range still fits in 64 bits
  localparam logic [63:0] CURSOR_TOP  = 64'd18446744073708;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef struct {
    logic [tbrm_pkg::TIME_NS_W-1:0] stamp_ns;
    logic [tbrm_pkg::BITS_IN_W-1:0] trig;
  } event_item_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [tbrm_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [tbrm_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]                       m_tuser;
  logic                             cfg_we    = 1'b0;
  logic [tbrm_pkg::CFG_IDX_W-1:0]   cfg_idx   = tbrm_pkg::CFG_WINDOW_MS;
  logic [tbrm_pkg::CFG_W-1:0]       cfg_wdata = '0;

  trigger_bit_rate_meter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state and register copies
  logic [tbrm_pkg::CFG_W-1:0]         window_len  = tbrm_pkg::CFG_RESET_VALUE;
  logic [tbrm_pkg::CFG_W-1:0]         gap_limit   = tbrm_pkg::CFG_RESET_VALUE;
  logic [tbrm_pkg::MS_W-1:0]          last_ms     = '0;
  logic [tbrm_pkg::WIN_W-1:0]         window_acc  = '0;
  logic [tbrm_pkg::TOTAL_W-1:0]       total_acc   = '0;
  logic [tbrm_pkg::COUNTER_WIDTH-1:0] line_count [tbrm_pkg::NUM_TRIGGER_BITS];

  event_item_t    event_queue[$];
  tbrm_pkg::res_t awaited_reports[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned failures       = 0;
  logic [63:0] cursor_ms      = '0;

  initial begin
    for (int k = 0; k < tbrm_pkg::NUM_TRIGGER_BITS; k++) line_count[k] = '0;
  end

  function automatic tbrm_pkg::res_t meter_event(logic [tbrm_pkg::TIME_NS_W-1:0] stamp_ns,
                                                 logic [tbrm_pkg::BITS_IN_W-1:0] trig);
    logic [63:0]                quot;
    logic [tbrm_pkg::MS_W-1:0]  now_ms;
    logic [tbrm_pkg::MS_W-1:0]  gap;
    logic [tbrm_pkg::TOTAL_W:0] tsum;
    logic [tbrm_pkg::MS_W:0]    wsum;
    tbrm_pkg::res_t             rep;
    quot   = stamp_ns / NS_PER_MS;
    now_ms = quot[tbrm_pkg::MS_W-1:0];
    gap    = (now_ms >= last_ms) ? now_ms - last_ms : last_ms - now_ms;
    if (gap > gap_limit) gap = '0;
    for (int k = 0; k < tbrm_pkg::NUM_TRIGGER_BITS; k++) begin
      if (trig[k] && line_count[k] != '1) line_count[k] = line_count[k] + 1'b1;
    end
    tsum = total_acc + gap;
    total_acc = tsum[tbrm_pkg::TOTAL_W] ? '1 : tsum[tbrm_pkg::TOTAL_W-1:0];
    wsum = window_acc + gap;
    window_acc = (wsum > {tbrm_pkg::WIN_W{1'b1}}) ? '1 : wsum[tbrm_pkg::WIN_W-1:0];
    rep = '0;
    rep.window_done = (window_acc > window_len);
    if (rep.window_done) begin
      for (int k = 0; k < tbrm_pkg::NUM_TRIGGER_BITS; k++) begin
        rep.count[k] = line_count[k][tbrm_pkg::COUNT_OUT_W-1:0];
        line_count[k] = '0;
      end
      window_acc = '0;
    end
    last_ms = now_ms;
    rep.total_time_ms = total_acc;
    return rep;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_n) begin : drive_events
    event_item_t item;
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready)
        awaited_reports = {awaited_reports, meter_event(s_tdata[63:0], s_tdata[71:64])};
      if (!s_tvalid || s_tready) begin
        if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = event_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {item.trig, item.stamp_ns};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with long hold-offs on request
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_reports
    tbrm_pkg::res_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (awaited_reports.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        want = awaited_reports.pop_front();
        if (m_tuser[0] !== want.window_done) begin
          $error("window_done: expected %0d, got %0d", want.window_done, m_tuser[0]);
          failures++;
        end
        for (int k = 0; k < tbrm_pkg::OUT_LINES; k++) begin
          if (m_tdata[k*tbrm_pkg::COUNT_OUT_W +: tbrm_pkg::COUNT_OUT_W] !== want.count[k]) begin
            $error("count_%0d: expected %0d, got %0d", k, want.count[k],
                   m_tdata[k*tbrm_pkg::COUNT_OUT_W +: tbrm_pkg::COUNT_OUT_W]);
            failures++;
          end
        end
        if (m_tdata[tbrm_pkg::OUT_TDATA_W-1 -: tbrm_pkg::TOTAL_W] !== want.total_time_ms) begin
          $error("total_time_ms: expected %0d, got %0d", want.total_time_ms,
                 m_tdata[tbrm_pkg::OUT_TDATA_W-1 -: tbrm_pkg::TOTAL_W]);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_event(input logic [63:0] stamp_ns, input logic [7:0] trig);
    event_item_t item;
    item.stamp_ns = stamp_ns;
    item.trig     = trig;
    event_queue   = {event_queue, item};
  endtask

  task automatic write_reg(input logic [tbrm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tbrm_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == tbrm_pkg::CFG_WINDOW_MS) window_len = val;
    else gap_limit = val;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (event_queue.size() != 0 || s_tvalid || awaited_reports.size() != 0)
      @(posedge clk_i);
  endtask

  // mostly a timestamp walk with gaps around the limit, some noise
  task automatic add_random_events(input int unsigned count);
    int unsigned pick;
    logic [63:0] step;
    logic [63:0] stamp;
    logic [7:0]  trig;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        stamp = {$urandom, $urandom};
        cursor_ms = stamp / NS_PER_MS;
        if (cursor_ms > CURSOR_TOP) cursor_ms = CURSOR_TOP;
      end else begin
        if (pick < 60) step = $urandom_range(gap_limit);
        else if (pick < 75) step = gap_limit + $urandom_range(2) - 1;
        else if (pick < 87) step = $urandom_range(3);
        else step = gap_limit + 1 + $urandom_range(100000);
        if ($urandom_range(99) < 10) begin
          if (step <= cursor_ms) cursor_ms = cursor_ms - step;
          else cursor_ms = cursor_ms + step;
        end else begin
          if (cursor_ms + step <= CURSOR_TOP) cursor_ms = cursor_ms + step;
          else cursor_ms = cursor_ms - step;
        end
        stamp = cursor_ms * NS_PER_MS + $urandom_range(999999);
      end
      pick = $urandom_range(9);
      trig = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
      add_event(stamp, trig);
    end
  endtask

  initial begin : stimulus
    logic [tbrm_pkg::CFG_W-1:0] win_set [8];
    logic [tbrm_pkg::CFG_W-1:0] gap_set [8];
    logic [63:0]                top_ns;
    win_set = '{16'd1, 16'd65535, 16'd50, 16'd3, 16'd300, 16'd7, 16'd1, 16'd1000};
    gap_set = '{16'd1, 16'd65535, 16'd20, 16'd65535, 16'd400, 16'd3, 16'd2, 16'd999};
    top_ns  = '1;

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset settings: window 1000, gap limit 1000
    @(negedge clk_i);
    add_event(64'd5000 * NS_PER_MS, 8'hFF);     // first event, gap dropped
    add_event(64'd0, 8'h00);
    add_event(64'd1000 * NS_PER_MS, 8'h0F);     // gap equals limit, window at length
    add_event(64'd1000 * NS_PER_MS + 64'd999999, 8'hF0);
    add_event(64'd1001 * NS_PER_MS, 8'h01);     // window one past length closes
    add_event(64'd2002 * NS_PER_MS, 8'h00);     // gap one past limit
    add_event(64'd1502 * NS_PER_MS, 8'h02);     // time goes backwards
    add_event(top_ns, 8'h80);
    add_event(top_ns - 64'd999 * NS_PER_MS, 8'h81);
    for (int k = 0; k < 8; k++)
      add_event((64'd3000 + 64'd300 * k) * NS_PER_MS, 8'h01 << k);
    add_event(64'd5101 * NS_PER_MS, 8'hAA);
    add_event(64'd5102 * NS_PER_MS, 8'h55);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(tbrm_pkg::CFG_WINDOW_MS, win_set[ph]);
      write_reg(tbrm_pkg::CFG_GAP_LIMIT_MS, gap_set[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 45;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 45;
        end
        default: begin
          send_idle_pct  <= 14;
          recv_stall_pct <= 14;
        end
      endcase
      @(negedge clk_i);
      cursor_ms = $urandom_range(1000000);
      add_random_events(135);
      // back-pressure: sink stops while the source keeps sending
      if (ph % 4 == 0) hold_requests <= hold_requests + 1;
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (failures == 0 && awaited_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
